// ===== src/nds_pkg.sv =====
`timescale 1ns / 1ps

package nds_pkg;

    // fixed field widths of the stream channels
    localparam int FIELD_W     = 16;
    localparam int INDEX_IN_W  = 8;
    localparam int INDEX_OUT_W = 8;
    localparam int SCORE_W     = 33;
    localparam int COUNT_W     = 9;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 48;
    localparam int M_PAD_W     = M_TDATA_W - SCORE_W - INDEX_OUT_W - 1;

    // operation codes carried in s_axis_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PUT
    } nds_state_t;

    // sideband that travels with each table read through the score pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } scan_ctl_t;

endpackage

// ===== src/nearest_direction_search.sv =====
`timescale 1ns / 1ps

// nearest direction search: table of direction vectors, argmax of dot product
// s_axis: one transfer per item; tuser selects a table write or a query
//   a write stores entry_x/y/z at entry_index and returns an acknowledge
//   a query scores query_x/y/z against entries 0 .. min(entry_count, TABLE_DEPTH)-1
// m_axis: exactly one result transfer per input item, in input order
// cfg_we/cfg_wdata set entry_count; write it only while the block is idle
// flow: a write or a trivial query (count zero, zero vector) goes from idle to
//   the put state and then into the output register once it is free; a searching
//   query scans those entries, one table read per cycle, from the table memory
//   through a three-stage score pipeline, then drains and moves to the put state
// one item is in work at a time; the next item is taken only once the previous
//   result has moved into the output register and the block is back in idle
// a stalled receiver holds m_axis steady; the block then waits with its
//   finished result and stops taking items until the register frees
// reset clears control state and entry_count; table contents stay undefined
//   until written, and a query must not reach an unwritten slot
module nearest_direction_search import nds_pkg::*; #(
    parameter int TABLE_DEPTH     = 256,
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // entry_index, entry_x, entry_y, entry_z, query_x, query_y, query_z
    input  logic [S_TDATA_W-1:0]   s_axis_tdata,
    // operation
    input  logic [0:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // found, nearest_index, best_score, zero padding
    output logic [M_TDATA_W-1:0]   m_axis_tdata,
    // was_query
    output logic [0:0]             m_axis_tuser,
    input  logic                   cfg_we,
    input  logic [COUNT_W-1:0]     cfg_wdata
);

    localparam int IB    = (COMPONENT_WIDTH < FIELD_W) ? COMPONENT_WIDTH : FIELD_W;
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW0   = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W = (CW0 > COUNT_W) ? CW0 : COUNT_W;
    localparam int SW    = 2 * IB + 2;

    // input field split
    logic                 in_op;
    logic [INDEX_IN_W-1:0] in_slot;
    logic [FIELD_W-1:0]   in_ex, in_ey, in_ez, in_qx, in_qy, in_qz;

    assign in_op   = s_axis_tuser[0];
    assign in_slot = s_axis_tdata[7:0];
    assign in_ex   = s_axis_tdata[23:8];
    assign in_ey   = s_axis_tdata[39:24];
    assign in_ez   = s_axis_tdata[55:40];
    assign in_qx   = s_axis_tdata[71:56];
    assign in_qy   = s_axis_tdata[87:72];
    assign in_qz   = s_axis_tdata[103:88];

    // table memory, one synchronous port each for write and read
    logic [3*IB-1:0] table_mem [TABLE_DEPTH];
    logic [3*IB-1:0] rd_data_reg;
    logic [AW-1:0]   rd_idx_reg;
    scan_ctl_t       rd_ctl_reg, rd_ctl_next;

    nds_state_t state_reg, state_next;

    logic [COUNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]     count_ext, search_len;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [AW-1:0]        last_reg, last_next;
    logic signed [IB-1:0] qx_reg, qy_reg, qz_reg;
    logic                 res_query_reg, res_query_next;
    logic                 res_found_reg, res_found_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_user_reg;

    logic s_fire, out_free, mem_we, load_query, slot_ok, query_zero, load_out;
    logic scan_end;

    logic [AW-1:0]          best_idx;
    logic signed [SW-1:0]   best_score;
    logic                   best_done;
    logic signed [SCORE_W-1:0] score_out;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // searched length is the count clamped to the table depth
    assign count_ext  = CNT_W'(count_reg);
    assign search_len = (count_ext > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_ext;
    assign slot_ok    = (32'(in_slot) < TABLE_DEPTH);
    assign query_zero = (in_qx[IB-1:0] == '0) && (in_qy[IB-1:0] == '0)
                        && (in_qz[IB-1:0] == '0);
    assign scan_end   = (addr_reg == last_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cfg_we) begin
            count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        res_query_next = res_query_reg;
        res_found_next = res_found_reg;
        mem_we         = 1'b0;
        load_query     = 1'b0;
        load_out       = 1'b0;
        rd_ctl_next    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (in_op == OP_WRITE) begin
                        mem_we         = slot_ok;
                        res_query_next = 1'b0;
                        res_found_next = 1'b0;
                        state_next     = ST_PUT;
                    end else if (search_len == '0 || query_zero) begin
                        res_query_next = 1'b1;
                        res_found_next = 1'b0;
                        state_next     = ST_PUT;
                    end else begin
                        load_query     = 1'b1;
                        res_query_next = 1'b1;
                        res_found_next = 1'b1;
                        addr_next      = '0;
                        last_next      = AW'(search_len - CNT_W'(1));
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_ctl_next = '{valid: 1'b1, first: (addr_reg == '0), last: scan_end};
                addr_next   = addr_reg + AW'(1);
                if (scan_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (best_done) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg      <= '0;
            last_reg      <= '0;
            res_query_reg <= 1'b0;
            res_found_reg <= 1'b0;
            rd_ctl_reg    <= '0;
        end else begin
            addr_reg      <= addr_next;
            last_reg      <= last_next;
            res_query_reg <= res_query_next;
            res_found_reg <= res_found_next;
            rd_ctl_reg    <= rd_ctl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_query) begin
            qx_reg <= $signed(in_qx[IB-1:0]);
            qy_reg <= $signed(in_qy[IB-1:0]);
            qz_reg <= $signed(in_qz[IB-1:0]);
        end
    end

    // table write on the accepting edge, read during the scan
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[AW'(in_slot)] <= {in_ez[IB-1:0], in_ey[IB-1:0], in_ex[IB-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN) begin
            rd_data_reg <= table_mem[addr_reg];
        end
        rd_idx_reg <= addr_reg;
    end

    nds_argmax #(
        .IB (IB),
        .AW (AW),
        .SW (SW)
    ) u_argmax (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_ctl     (rd_ctl_reg),
        .in_idx     (rd_idx_reg),
        .in_entry   (rd_data_reg),
        .qx         (qx_reg),
        .qy         (qy_reg),
        .qz         (qz_reg),
        .best_idx   (best_idx),
        .best_score (best_score),
        .done       (best_done)
    );

    // score always fits the result width for components up to 16 bits
    assign score_out = SCORE_W'(best_score);

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_user_reg <= res_query_reg;
            if (res_found_reg) begin
                m_data_reg <= {{M_PAD_W{1'b0}}, score_out, INDEX_OUT_W'(best_idx), 1'b1};
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_user_reg;

endmodule

// ===== src/nds_argmax.sv =====
`timescale 1ns / 1ps

module nds_argmax import nds_pkg::*; #(
    parameter int IB  = 16,
    parameter int AW  = 8,
    parameter int SW  = 2 * IB + 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scan_ctl_t            in_ctl,
    input  logic [AW-1:0]        in_idx,
    input  logic [3*IB-1:0]      in_entry,
    input  logic signed [IB-1:0] qx,
    input  logic signed [IB-1:0] qy,
    input  logic signed [IB-1:0] qz,
    output logic [AW-1:0]        best_idx,
    output logic signed [SW-1:0] best_score,
    output logic                 done
);

    logic signed [IB-1:0]   ex, ey, ez;
    logic signed [2*IB-1:0] px_reg, py_reg, pz_reg;
    logic signed [SW-1:0]   sum_reg;
    logic signed [SW-1:0]   best_reg;
    logic [AW-1:0]          idx1_reg, idx2_reg, best_idx_reg;
    scan_ctl_t              ctl1_reg, ctl2_reg;
    logic                   done_reg;

    assign ex = $signed(in_entry[IB-1:0]);
    assign ey = $signed(in_entry[2*IB-1:IB]);
    assign ez = $signed(in_entry[3*IB-1:2*IB]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            done_reg <= ctl2_reg.valid && ctl2_reg.last;
        end
    end

    // products, then the three-way sum
    always_ff @(posedge aclk) begin
        px_reg   <= qx * ex;
        py_reg   <= qy * ey;
        pz_reg   <= qz * ez;
        idx1_reg <= in_idx;
        sum_reg  <= SW'(px_reg) + SW'(py_reg) + SW'(pz_reg);
        idx2_reg <= idx1_reg;
    end

    // strict compare keeps the lowest index on ties
    always_ff @(posedge aclk) begin
        if (ctl2_reg.valid && (ctl2_reg.first || sum_reg > best_reg)) begin
            best_reg     <= sum_reg;
            best_idx_reg <= idx2_reg;
        end
    end

    assign best_idx   = best_idx_reg;
    assign best_score = best_reg;
    assign done       = done_reg;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import nds_pkg::*;

    localparam int DEPTH      = 256;
    localparam int WDOG_LIMIT = 5000;
    localparam int TAIL_WAIT  = 300;

    // one input item, unpacked
    typedef struct {
        logic               op;
        logic [7:0]         slot;
        logic signed [15:0] ex, ey, ez;
        logic signed [15:0] qx, qy, qz;
    } dir_item_t;

    // one result, fields in the order was_query, found, index, score
    typedef struct packed {
        logic        was_query;
        logic        found;
        logic [7:0]  index;
        logic [32:0] score;
    } dir_result_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // entry_index, entry_x, entry_y, entry_z, query_x, query_y, query_z
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // operation
    logic [0:0]           s_axis_tuser  = OP_WRITE;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // found, nearest_index, best_score, zero padding
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // was_query
    logic [0:0]           m_axis_tuser;
    logic                 cfg_we        = 1'b0;
    logic [COUNT_W-1:0]   cfg_wdata     = '0;

    nearest_direction_search #(
        .TABLE_DEPTH     (DEPTH),
        .COMPONENT_WIDTH (16)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // items waiting to be sent, and results the predictor says are due
    dir_item_t   pending_items[$];
    dir_result_t due_results[$];

    // predictor copy of the block state
    logic signed [15:0] dir_x [DEPTH];
    logic signed [15:0] dir_y [DEPTH];
    logic signed [15:0] dir_z [DEPTH];
    logic [COUNT_W-1:0] search_count = '0;

    // which slots the stimulus has written so far, so no query reaches a blank one
    bit [DEPTH-1:0] slot_written = '0;

    int in_count   = 0;
    int out_count  = 0;
    int mismatches = 0;
    int send_idle_pct, recv_idle_pct;

    // idling schedule follows how far the run has got:
    // sender light / receiver heavy, then swapped, then no idling at all
    always_comb begin
        if (in_count < 450) begin
            send_idle_pct = 7;
            recv_idle_pct = 79;
        end else if (in_count < 900) begin
            send_idle_pct = 79;
            recv_idle_pct = 7;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    end

    // dot product argmax over the first min(search_count, DEPTH) entries, lowest index on ties
    function automatic dir_result_t predict_direction_result(input dir_item_t it);
        dir_result_t r;
        longint      s, best;
        int          n, best_idx, i;
        bit          have;
        r = '0;
        if (it.op == OP_WRITE) begin
            dir_x[it.slot] = it.ex;
            dir_y[it.slot] = it.ey;
            dir_z[it.slot] = it.ez;
            return r;
        end
        r.was_query = 1'b1;
        n = (search_count > DEPTH) ? DEPTH : int'(search_count);
        if (n == 0 || (it.qx == 0 && it.qy == 0 && it.qz == 0))
            return r;
        have     = 1'b0;
        best     = 0;
        best_idx = 0;
        for (i = 0; i < n; i++) begin
            s = longint'(it.qx) * longint'(dir_x[i])
              + longint'(it.qy) * longint'(dir_y[i])
              + longint'(it.qz) * longint'(dir_z[i]);
            if (!have || s > best) begin
                best     = s;
                best_idx = i;
                have     = 1'b1;
            end
        end
        r.found = 1'b1;
        r.index = best_idx[7:0];
        r.score = best[32:0];
        return r;
    endfunction

    // sender: a new item goes out only once the current one has been taken
    always @(posedge aclk) begin
        dir_item_t it;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                it = pending_items.pop_front();
                s_axis_tdata  <= {it.qz, it.qy, it.qx, it.ez, it.ey, it.ex, it.slot};
                s_axis_tuser  <= it.op;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off to fill the block up
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && in_count >= 1000) begin
            hold_done     <= 1'b1;
            hold_left     <= 400;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: predicts on each input transfer, checks each output transfer
    always @(posedge aclk) begin
        dir_item_t   it;
        dir_result_t got, want;
        if (aresetn) begin
            if (cfg_we)
                search_count = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                it.op   = s_axis_tuser[0];
                it.slot = s_axis_tdata[7:0];
                it.ex   = s_axis_tdata[23:8];
                it.ey   = s_axis_tdata[39:24];
                it.ez   = s_axis_tdata[55:40];
                it.qx   = s_axis_tdata[71:56];
                it.qy   = s_axis_tdata[87:72];
                it.qz   = s_axis_tdata[103:88];
                due_results.insert(due_results.size(), predict_direction_result(it));
                in_count <= in_count + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser[0], m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[41:9]};
                out_count <= out_count + 1;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer %0d: q=%0b f=%0b idx=%0d score=%0d",
                                 out_count, got.was_query, got.found, got.index,
                                 $signed(got.score));
                end else begin
                    want = due_results.pop_front();
                    if (got.was_query != want.was_query || got.found != want.found ||
                        got.index != want.index || got.score != want.score) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d: exp %0b %0b %0d %0d / got %0b %0b %0d %0d",
                                     out_count, want.was_query, want.found, want.index,
                                     $signed(want.score), got.was_query, got.found,
                                     got.index, $signed(got.score));
                    end
                end
            end
        end
    end

    // watchdog: cycles in a row with no transfer on any port
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we ||
            !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus helpers

    function automatic logic signed [15:0] rand_component();
        logic signed [15:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 2))
                    0:       v = 16'sh8000;
                    1:       v = 16'sh7fff;
                    default: v = 16'sh0000;
                endcase
            end
            // small magnitudes make equal scores, so the tie rule gets exercised
            1, 2: begin
                v = $signed(16'($urandom_range(0, 4)));
                v = v - 16'sd2;
            end
            default: v = $signed(16'($urandom()));
        endcase
        return v;
    endfunction

    task automatic push_write(input int slot, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic signed [15:0] z);
        dir_item_t it;
        it.op   = OP_WRITE;
        it.slot = slot[7:0];
        it.ex   = x;
        it.ey   = y;
        it.ez   = z;
        // query fields are don't-care on a write, so fill them with noise
        it.qx   = $signed(16'($urandom()));
        it.qy   = $signed(16'($urandom()));
        it.qz   = $signed(16'($urandom()));
        slot_written[slot] = 1'b1;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic push_query(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z);
        dir_item_t it;
        it.op   = OP_QUERY;
        it.slot = 8'($urandom());
        it.ex   = $signed(16'($urandom()));
        it.ey   = $signed(16'($urandom()));
        it.ez   = $signed(16'($urandom()));
        it.qx   = x;
        it.qy   = y;
        it.qz   = z;
        pending_items.insert(pending_items.size(), it);
    endtask

    // block is idle once everything sent has come back
    task automatic wait_idle();
        do
            @(posedge aclk);
        while (pending_items.size() != 0 || s_axis_tvalid || due_results.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_count(input int n);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= n[COUNT_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // one random phase: set the count, fill any blank slot it covers, then mix
    task automatic random_phase(input int n, input int items);
        int lim, i;
        write_count(n);
        lim = (n > DEPTH) ? DEPTH : n;
        for (i = 0; i < lim; i++)
            if (!slot_written[i])
                push_write(i, rand_component(), rand_component(), rand_component());
        for (i = 0; i < items; i++) begin
            if ($urandom_range(0, 99) < 45)
                push_write(int'($urandom_range(0, DEPTH - 1)), rand_component(),
                           rand_component(), rand_component());
            else if ($urandom_range(0, 19) == 0)
                push_query(16'sd0, 16'sd0, 16'sd0);
            else
                push_query(rand_component(), rand_component(), rand_component());
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: count still zero from reset, so queries find nothing
        push_query(16'sd5, -16'sd7, 16'sd1);
        push_query(16'sd0, 16'sd0, 16'sd0);
        push_write(0, 16'sd16384, 16'sd0, 16'sd0);
        push_write(1, 16'sh8000, 16'sh8000, 16'sh8000);
        push_write(2, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        push_write(3, 16'sd16384, 16'sd0, 16'sd0);
        push_write(255, 16'sd0, 16'sd0, -16'sd16384);

        write_count(4);
        push_query(16'sd1, 16'sd0, 16'sd0);
        // most positive score the fields allow
        push_query(16'sh8000, 16'sh8000, 16'sh8000);
        // slot 1 scores negative, the other slots positive, slot 2 highest
        push_query(16'sh7fff, 16'sh7fff, 16'sh7fff);
        push_query(16'sd0, -16'sd5, 16'sd0);
        // slots 0 and 3 tie for the best score, lower index must win
        push_query(16'sd1, -16'sd1, 16'sd0);
        // zero query with a non-empty table
        push_query(16'sd0, 16'sd0, 16'sd0);
        // write to the last slot, then a single-entry search
        push_write(255, 16'sh7fff, 16'sh8000, 16'sd1);
        write_count(1);
        push_query(-16'sd1, -16'sd1, -16'sd1);
        push_query(16'sh7fff, 16'sh8000, 16'sh7fff);

        // random phases: mostly small counts, a few full and over-range ones
        random_phase(3, 150);
        random_phase(DEPTH, 50);
        random_phase(1, 100);
        random_phase(0, 60);
        random_phase(17, 150);
        random_phase(511, 30);
        random_phase(64, 90);
        random_phase(2, 120);
        random_phase(300, 30);
        random_phase(9, 150);
        random_phase(128, 50);
        random_phase(5, 120);

        wait_idle();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== nearest_direction_search.f =====
src/nds_pkg.sv
src/nds_argmax.sv
src/nearest_direction_search.sv
sim/tb_top.sv
